FILE: src/xlsr_pkg.sv
// Package for the x86 logic, shift and rotate unit: operation codes, operand size codes
// and the word types shared by the datapath and the top level.
// Depends on nothing.
package xlsr_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = 5;

    // Operation codes carried in req_type.
    localparam logic [3:0] OP_TEST = 4'd0;
    localparam logic [3:0] OP_AND  = 4'd1;
    localparam logic [3:0] OP_XOR  = 4'd2;
    localparam logic [3:0] OP_OR   = 4'd3;
    localparam logic [3:0] OP_NOT  = 4'd4;
    localparam logic [3:0] OP_SAR  = 4'd5;
    localparam logic [3:0] OP_SHL  = 4'd6;
    localparam logic [3:0] OP_SHR  = 4'd7;
    localparam logic [3:0] OP_ROL  = 4'd8;
    localparam logic [3:0] OP_ROR  = 4'd9;
    localparam logic [3:0] OP_RCL  = 4'd10;
    localparam logic [3:0] OP_RCR  = 4'd11;

    // Operand size codes carried in width_code; the unused code counts as doubleword.
    localparam logic [1:0] WC_BYTE = 2'd0;
    localparam logic [1:0] WC_WORD = 2'd1;

    typedef struct packed {
        logic sf;
        logic zf;
        logic of;
        logic cf;
    } flags_t;

    typedef struct packed {
        logic [3:0]           req_type;
        logic [WORD_BITS-1:0] dest_value;
        logic [WORD_BITS-1:0] src_value;
        logic [1:0]           width_code;
    } req_word_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] result_value;
        logic                 write_back;
        logic                 carry_flag;
        logic                 overflow_flag;
        logic                 zero_flag;
        logic                 sign_flag;
    } rsp_word_t;

endpackage

FILE: src/xlsr_if.sv
// Handshake channels of the x86 logic, shift and rotate unit: request and response.
// Depends on xlsr_pkg.
interface xlsr_req_if
    import xlsr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [3:0]           req_type;
    logic [WORD_BITS-1:0] dest_value;
    logic [WORD_BITS-1:0] src_value;
    logic [1:0]           width_code;

    modport source (
        output valid, req_type, dest_value, src_value, width_code,
        input  ready
    );
    modport sink (
        input  valid, req_type, dest_value, src_value, width_code,
        output ready
    );
endinterface

interface xlsr_rsp_if
    import xlsr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] result_value;
    logic                 write_back;
    logic                 carry_flag;
    logic                 overflow_flag;
    logic                 zero_flag;
    logic                 sign_flag;

    modport source (
        output valid, result_value, write_back, carry_flag, overflow_flag,
               zero_flag, sign_flag,
        input  ready
    );
    modport sink (
        input  valid, result_value, write_back, carry_flag, overflow_flag,
               zero_flag, sign_flag,
        output ready
    );
endinterface

FILE: src/xlsr_core.sv
// Combinational datapath of the x86 logic, shift and rotate unit: logic operations,
// barrel shifts, rotates and the flag update. Depends on xlsr_pkg.
module xlsr_core
    import xlsr_pkg::*;
(
    input  req_word_t req_data,
    input  flags_t    flags_in,
    output rsp_word_t rsp_data,
    output flags_t    flags_out
);

    // Bit n-1 of a value for the operand size in use.
    function automatic logic top_bit(input logic [WORD_BITS-1:0] val, input logic [1:0] wc);
        logic b;
        unique case (wc)
            WC_BYTE: b = val[7];
            WC_WORD: b = val[15];
            default: b = val[WORD_BITS-1];
        endcase
        return b;
    endfunction

    // Bit n-2 of a value for the operand size in use.
    function automatic logic next_bit(input logic [WORD_BITS-1:0] val, input logic [1:0] wc);
        logic b;
        unique case (wc)
            WC_BYTE: b = val[6];
            WC_WORD: b = val[14];
            default: b = val[WORD_BITS-2];
        endcase
        return b;
    endfunction

    // Count modulo nine by a single subtraction of 27, 18 or 9.
    function automatic logic [3:0] mod_nine(input logic [CNT_BITS-1:0] c);
        logic [CNT_BITS-1:0] m;
        if (c >= 5'd27)
        begin
            m = c - 5'd27;
        end
        else if (c >= 5'd18)
        begin
            m = c - 5'd18;
        end
        else if (c >= 5'd9)
        begin
            m = c - 5'd9;
        end
        else
        begin
            m = c;
        end
        return m[3:0];
    endfunction

    logic [WORD_BITS-1:0]   wmask;
    logic [WORD_BITS-1:0]   d;
    logic [WORD_BITS-1:0]   s;
    logic [CNT_BITS-1:0]    cnt;
    logic [WORD_BITS-1:0]   d_sx;
    logic [WORD_BITS-1:0]   sar_r;
    logic [2*WORD_BITS-2:0] shl_full;
    logic [WORD_BITS-1:0]   shl_r;
    logic                   shl_lost;
    logic [WORD_BITS-1:0]   shr_r;
    logic [15:0]            rol8;
    logic [15:0]            ror8;
    logic [31:0]            rol16;
    logic [31:0]            ror16;
    logic [63:0]            rol32;
    logic [63:0]            ror32;
    logic [WORD_BITS-1:0]   rol_r;
    logic [WORD_BITS-1:0]   ror_r;
    logic [3:0]             t9;
    logic [CNT_BITS-1:0]    t17;
    logic [8:0]             v9;
    logic [16:0]            v17;
    logic [32:0]            v33;
    logic [17:0]            rcl9;
    logic [17:0]            rcr9;
    logic [33:0]            rcl17;
    logic [33:0]            rcr17;
    logic [65:0]            rcl33;
    logic [65:0]            rcr33;
    logic [WORD_BITS-1:0]   rcl_r;
    logic [WORD_BITS-1:0]   rcr_r;
    logic                   rcl_c;
    logic                   rcr_c;
    logic [WORD_BITS-1:0]   r;
    logic                   wb;
    flags_t                 f;
    logic                   rot_c;

    // Operand masking and the shift count.
    always_comb
    begin
        unique case (req_data.width_code)
            WC_BYTE:
            begin
                wmask = 32'h0000_00ff;
                d_sx  = {{24{req_data.dest_value[7]}}, req_data.dest_value[7:0]};
            end
            WC_WORD:
            begin
                wmask = 32'h0000_ffff;
                d_sx  = {{16{req_data.dest_value[15]}}, req_data.dest_value[15:0]};
            end
            default:
            begin
                wmask = 32'hffff_ffff;
                d_sx  = req_data.dest_value;
            end
        endcase
        d   = req_data.dest_value & wmask;
        s   = req_data.src_value;
        cnt = req_data.src_value[CNT_BITS-1:0];
    end

    // Shifts. A left shift into a double-width word shows every bit that leaves the operand.
    always_comb
    begin
        sar_r    = WORD_BITS'($signed(d_sx) >>> cnt) & wmask;
        shl_full = {{(WORD_BITS-1){1'b0}}, d} << cnt;
        shl_r    = shl_full[WORD_BITS-1:0] & wmask;
        shl_lost = |(shl_full & ~{{(WORD_BITS-1){1'b0}}, wmask});
        shr_r    = d >> cnt;
    end

    // Plain rotates, one doubled operand per size.
    always_comb
    begin
        rol8  = {d[7:0], d[7:0]} << cnt[2:0];
        ror8  = {d[7:0], d[7:0]} >> cnt[2:0];
        rol16 = {d[15:0], d[15:0]} << cnt[3:0];
        ror16 = {d[15:0], d[15:0]} >> cnt[3:0];
        rol32 = {d, d} << cnt;
        ror32 = {d, d} >> cnt;
        unique case (req_data.width_code)
            WC_BYTE:
            begin
                rol_r = {24'd0, rol8[15:8]};
                ror_r = {24'd0, ror8[7:0]};
            end
            WC_WORD:
            begin
                rol_r = {16'd0, rol16[31:16]};
                ror_r = {16'd0, ror16[15:0]};
            end
            default:
            begin
                rol_r = rol32[63:32];
                ror_r = ror32[31:0];
            end
        endcase
    end

    // Rotates through carry over size plus one bits.
    always_comb
    begin
        t9    = mod_nine(cnt);
        t17   = (cnt >= 5'd17) ? (cnt - 5'd17) : cnt;
        v9    = {flags_in.cf, d[7:0]};
        v17   = {flags_in.cf, d[15:0]};
        v33   = {flags_in.cf, d};
        rcl9  = {v9, v9} << t9;
        rcr9  = {v9, v9} >> t9;
        rcl17 = {v17, v17} << t17;
        rcr17 = {v17, v17} >> t17;
        rcl33 = {v33, v33} << cnt;
        rcr33 = {v33, v33} >> cnt;
        unique case (req_data.width_code)
            WC_BYTE:
            begin
                rcl_r = {24'd0, rcl9[16:9]};
                rcl_c = rcl9[17];
                rcr_r = {24'd0, rcr9[7:0]};
                rcr_c = rcr9[8];
            end
            WC_WORD:
            begin
                rcl_r = {16'd0, rcl17[32:17]};
                rcl_c = rcl17[33];
                rcr_r = {16'd0, rcr17[15:0]};
                rcr_c = rcr17[16];
            end
            default:
            begin
                rcl_r = rcl33[64:33];
                rcl_c = rcl33[65];
                rcr_r = rcr33[31:0];
                rcr_c = rcr33[32];
            end
        endcase
    end

    // Result selection and flag update.
    always_comb
    begin
        r     = d;
        wb    = 1'b1;
        f     = flags_in;
        rot_c = 1'b0;
        unique case (req_data.req_type)
            OP_TEST, OP_AND, OP_XOR, OP_OR:
            begin
                if (req_data.req_type == OP_XOR)
                begin
                    r = (d ^ s) & wmask;
                end
                else if (req_data.req_type == OP_OR)
                begin
                    r = (d | s) & wmask;
                end
                else
                begin
                    r = d & s;
                end
                wb   = (req_data.req_type != OP_TEST);
                f.cf = 1'b0;
                f.of = 1'b0;
                f.zf = (r == '0);
                f.sf = top_bit(r, req_data.width_code);
            end
            OP_NOT:
            begin
                r = ~d & wmask;
            end
            OP_SAR, OP_SHR:
            begin
                r    = (req_data.req_type == OP_SAR) ? sar_r : shr_r;
                f.cf = 1'b0;
                f.of = 1'b0;
                f.zf = (r == '0);
                f.sf = top_bit(r, req_data.width_code);
            end
            OP_SHL:
            begin
                r    = shl_r;
                f.cf = shl_lost;
                f.of = shl_lost;
                f.zf = (r == '0);
                f.sf = top_bit(r, req_data.width_code);
            end
            OP_ROL, OP_ROR:
            begin
                // Flags move only for a non-zero count; OF only for a count of one.
                if (req_data.req_type == OP_ROL)
                begin
                    r     = rol_r;
                    rot_c = rol_r[0];
                end
                else
                begin
                    r     = ror_r;
                    rot_c = top_bit(ror_r, req_data.width_code);
                end
                if (cnt != '0)
                begin
                    f.cf = rot_c;
                end
                if (cnt == 5'd1)
                begin
                    if (req_data.req_type == OP_ROL)
                    begin
                        f.of = top_bit(r, req_data.width_code) ^ rot_c;
                    end
                    else
                    begin
                        f.of = top_bit(r, req_data.width_code) ^
                               next_bit(r, req_data.width_code);
                    end
                end
            end
            OP_RCL:
            begin
                r    = rcl_r;
                f.cf = rcl_c;
                if (cnt == 5'd1)
                begin
                    f.of = top_bit(rcl_r, req_data.width_code) ^ rcl_c;
                end
            end
            OP_RCR:
            begin
                r    = rcr_r;
                f.cf = rcr_c;
                if (cnt == 5'd1)
                begin
                    f.of = top_bit(d, req_data.width_code) ^ flags_in.cf;
                end
            end
            default:
            begin
                // Unused codes pass the masked destination and write nothing back.
                wb = 1'b0;
            end
        endcase
    end

    assign flags_out              = f;
    assign rsp_data.result_value  = r;
    assign rsp_data.write_back    = wb;
    assign rsp_data.carry_flag    = f.cf;
    assign rsp_data.overflow_flag = f.of;
    assign rsp_data.zero_flag     = f.zf;
    assign rsp_data.sign_flag     = f.sf;

endmodule

FILE: src/x86_logic_shift_rotate_alu_unit.sv
// Top level of the x86 logic, shift and rotate unit: input register, datapath, result
// register and the flag register. Depends on xlsr_pkg, xlsr_if and xlsr_core.
//
//  Channel  Role             Word contents
//  req      sink (in)        req_type, dest_value, src_value, width_code
//  rsp      source (out)     result_value, write_back, carry_flag, overflow_flag,
//                            zero_flag, sign_flag
//
// A word is accepted every cycle while the response side keeps up. It is held in the input
// register, passes the datapath into the result register and is shown on rsp from there.
// The flag register updates as each word passes the datapath, so the next word sees it.
// The two registers together hold two words, so a stalled response side stops requests
// only once both are full. Reset clears both valid bits and all four flags.
module x86_logic_shift_rotate_alu_unit
    import xlsr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    xlsr_req_if.sink   req,
    xlsr_rsp_if.source rsp
);

    req_word_t in_reg;
    logic      in_valid_reg;
    rsp_word_t out_reg;
    logic      out_valid_reg;
    flags_t    flags_reg;
    rsp_word_t rsp_next;
    flags_t    flags_next;
    logic      advance;
    logic      in_take;

    // Pipeline control: the input stage moves on when the result register frees up.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign in_take   = req.valid && req.ready;

    xlsr_core u_core (
        .req_data  (in_reg),
        .flags_in  (flags_reg),
        .rsp_data  (rsp_next),
        .flags_out (flags_next)
    );

    // Valid bits and flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg.req_type   <= req.req_type;
            in_reg.dest_value <= req.dest_value;
            in_reg.src_value  <= req.src_value;
            in_reg.width_code <= req.width_code;
        end
        if (advance)
        begin
            out_reg <= rsp_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.result_value  = out_reg.result_value;
    assign rsp.write_back    = out_reg.write_back;
    assign rsp.carry_flag    = out_reg.carry_flag;
    assign rsp.overflow_flag = out_reg.overflow_flag;
    assign rsp.zero_flag     = out_reg.zero_flag;
    assign rsp.sign_flag     = out_reg.sign_flag;

endmodule

FILE: src/xlsr_checker.sv
// Port-level checks for the x86 logic, shift and rotate unit, and the bind that attaches
// them to the top level. Depends on xlsr_pkg.
module xlsr_checker
    import xlsr_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 req_valid,
    input logic                 req_ready,
    input logic                 rsp_valid,
    input logic                 rsp_ready,
    input logic [WORD_BITS-1:0] rsp_result_value,
    input logic                 rsp_write_back
);

    logic [1:0] inflight_reg;
    logic       req_take;
    logic       rsp_take;

    assign req_take = req_valid && req_ready;
    assign rsp_take = rsp_valid && rsp_ready;

    // Words accepted but not yet delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 2'd0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 2'(req_take) - 2'(rsp_take);
        end
    end

    // No response is shown while reset is applied.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

    // The unit never holds more than its two register stages.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n) inflight_reg <= 2'd2)
        else $error("more than two words in flight");

    // A response only appears for a word that was accepted.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> inflight_reg != 2'd0)
        else $error("response without an accepted word");

    // Requests stall only behind a stalled response.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> (rsp_valid && !rsp_ready))
        else $error("request side stalled without back-pressure");

    // A stalled response holds its word.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
                                    && $stable(rsp_write_back))
        else $error("stalled response changed");

endmodule

bind x86_logic_shift_rotate_alu_unit xlsr_checker u_xlsr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_result_value (rsp.result_value),
    .rsp_write_back   (rsp.write_back)
);

FILE: tb/tb.sv
// Self-checking testbench for the x86 logic, shift and rotate unit: directed and random
// request words, a flag-tracking scoreboard and randomly stalling handshakes on both sides.
// Depends on xlsr_pkg, xlsr_if and x86_logic_shift_rotate_alu_unit.
`timescale 1ns / 1ps

module tb;
    import xlsr_pkg::*;

    // Request codes that the package does not name.
    localparam logic [3:0] OP_SPARE_LO = 4'd12;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;
    localparam logic [1:0] WC_DWORD    = 2'd2;
    localparam logic [1:0] WC_SPARE    = 2'd3;

    localparam int RANDOM_WORDS = 500;
    localparam int MAX_GAP      = 15;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    // Expected responses in order, with a private copy of the flag register.
    class alu_result_board;
        rsp_word_t pending_results[$];
        flags_t    flag_state;
        int        mismatches;
        int        checked;

        function new();
            flag_state = '0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_zero_sign(logic [63:0] r, int n);
            flag_state.zf = (r == 64'd0);
            flag_state.sf = r[n-1];
        endfunction

        // Executes one request word and updates the flag copy.
        function rsp_word_t compute_result(req_word_t w);
            rsp_word_t   o;
            int          n;
            int          cnt;
            int          t;
            logic [63:0] wm;
            logic [63:0] d;
            logic [63:0] s;
            logic [63:0] r;
            logic [63:0] v;
            logic [63:0] m;
            logic [63:0] rr;
            logic        cin;
            logic        c;
            logic        shifted_out;

            n   = (w.width_code == WC_BYTE) ? 8 : (w.width_code == WC_WORD) ? 16 : WORD_BITS;
            wm  = (64'd1 << n) - 64'd1;
            d   = {32'd0, w.dest_value} & wm;
            s   = {32'd0, w.src_value};
            cnt = w.src_value[CNT_BITS-1:0];
            cin = flag_state.cf;
            r   = d;
            o.write_back = 1'b1;

            case (w.req_type)
                OP_TEST, OP_AND, OP_XOR, OP_OR:
                begin
                    if (w.req_type == OP_XOR)
                        r = (d ^ s) & wm;
                    else if (w.req_type == OP_OR)
                        r = (d | s) & wm;
                    else
                        r = d & s & wm;
                    if (w.req_type == OP_TEST)
                        o.write_back = 1'b0;
                    flag_state.cf = 1'b0;
                    flag_state.of = 1'b0;
                    set_zero_sign(r, n);
                end
                OP_NOT:
                begin
                    r = ~d & wm;
                end
                OP_SAR:
                begin
                    v = d;
                    if (d[n-1])
                        v = v | ~wm;
                    r = ((v >> cnt) | (d[n-1] ? ~({64{1'b1}} >> cnt) : 64'd0)) & wm;
                    flag_state.cf = 1'b0;
                    flag_state.of = 1'b0;
                    set_zero_sign(r, n);
                end
                OP_SHL:
                begin
                    r = (d << cnt) & wm;
                    shifted_out = ((r >> cnt) != d);
                    flag_state.cf = shifted_out;
                    flag_state.of = shifted_out;
                    set_zero_sign(r, n);
                end
                OP_SHR:
                begin
                    r = d >> cnt;
                    flag_state.cf = 1'b0;
                    flag_state.of = 1'b0;
                    set_zero_sign(r, n);
                end
                OP_ROL, OP_ROR:
                begin
                    t = cnt % n;
                    if (w.req_type == OP_ROL)
                        r = ((d << t) | (d >> (n - t))) & wm;
                    else
                        r = ((d >> t) | (d << (n - t))) & wm;
                    if (cnt != 0)
                    begin
                        c = (w.req_type == OP_ROL) ? r[0] : r[n-1];
                        flag_state.cf = c;
                        if (cnt == 1)
                            flag_state.of = (w.req_type == OP_ROL) ? (r[n-1] ^ c)
                                                                    : (r[n-1] ^ r[n-2]);
                    end
                end
                OP_RCL, OP_RCR:
                begin
                    // The carry rides above the operand as one extra bit.
                    t  = (n == WORD_BITS) ? cnt : cnt % (n + 1);
                    v  = ({63'd0, cin} << n) | d;
                    m  = (64'd1 << (n + 1)) - 64'd1;
                    if (w.req_type == OP_RCL)
                        rr = ((v << t) | (v >> (n + 1 - t))) & m;
                    else
                        rr = ((v >> t) | (v << (n + 1 - t))) & m;
                    r = rr & wm;
                    flag_state.cf = rr[n];
                    if (cnt == 1)
                        flag_state.of = (w.req_type == OP_RCL) ? (r[n-1] ^ rr[n])
                                                                : (d[n-1] ^ cin);
                end
                default:
                begin
                    o.write_back = 1'b0;
                end
            endcase

            o.result_value  = r[WORD_BITS-1:0];
            o.carry_flag    = flag_state.cf;
            o.overflow_flag = flag_state.of;
            o.zero_flag     = flag_state.zf;
            o.sign_flag     = flag_state.sf;
            return o;
        endfunction

        function void note_request(req_word_t w);
            pending_results.push_back(compute_result(w));
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compares one accepted response word with the oldest expectation.
        task check_response(rsp_word_t got);
            rsp_word_t exp_word;
            if (pending_results.size() == 0)
            begin
                report($sformatf("response word %h with nothing expected", got));
            end
            else
            begin
                exp_word = pending_results.pop_front();
                checked++;
                if (got.result_value !== exp_word.result_value)
                    report($sformatf("result_value %h, expected %h",
                                     got.result_value, exp_word.result_value));
                if (got.write_back !== exp_word.write_back)
                    report($sformatf("write_back %b, expected %b",
                                     got.write_back, exp_word.write_back));
                if (got.carry_flag !== exp_word.carry_flag)
                    report($sformatf("carry_flag %b, expected %b",
                                     got.carry_flag, exp_word.carry_flag));
                if (got.overflow_flag !== exp_word.overflow_flag)
                    report($sformatf("overflow_flag %b, expected %b",
                                     got.overflow_flag, exp_word.overflow_flag));
                if (got.zero_flag !== exp_word.zero_flag)
                    report($sformatf("zero_flag %b, expected %b",
                                     got.zero_flag, exp_word.zero_flag));
                if (got.sign_flag !== exp_word.sign_flag)
                    report($sformatf("sign_flag %b, expected %b",
                                     got.sign_flag, exp_word.sign_flag));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic hold_rsp;
    int   accepted_reqs;
    int   cycle_count;

    xlsr_req_if req_ch ();
    xlsr_rsp_if rsp_ch ();

    alu_result_board board = new();

    x86_logic_shift_rotate_alu_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Run limit, far above the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run limit of %0d cycles reached with %0d words outstanding",
                     CYCLE_LIMIT, board.pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function req_word_t make_req(logic [3:0] op, logic [31:0] d, logic [31:0] s,
                                 logic [1:0] wc);
        req_word_t w;
        w.req_type   = op;
        w.dest_value = d;
        w.src_value  = s;
        w.width_code = wc;
        return w;
    endfunction

    // Random request word, biased towards boundary operands and counts.
    function req_word_t random_req();
        req_word_t   w;
        int          n;
        int          pick;
        logic [31:0] upper;
        logic [4:0]  cnt;

        w.req_type   = ($urandom_range(0, 99) < 4) ? 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
                                                    : 4'($urandom_range(OP_TEST, OP_RCR));
        w.width_code = ($urandom_range(0, 9) == 0) ? WC_SPARE : 2'($urandom_range(0, 2));
        n = (w.width_code == WC_BYTE) ? 8 : (w.width_code == WC_WORD) ? 16 : WORD_BITS;

        pick = $urandom_range(0, 7);
        case (pick)
            0:       w.dest_value = 32'd0;
            1:       w.dest_value = 32'hffff_ffff;
            2:       w.dest_value = 32'd1 << $urandom_range(0, 31);
            3:       w.dest_value = ($urandom & 32'hffff_ff00) | (32'd1 << (n - 1));
            default: w.dest_value = $urandom;
        endcase

        upper = $urandom;
        if (w.req_type >= OP_SAR && w.req_type <= OP_RCR && $urandom_range(0, 1) == 1)
        begin
            case ($urandom_range(0, 6))
                0:       cnt = 5'd0;
                1:       cnt = 5'd1;
                2:       cnt = 5'(n - 1);
                3:       cnt = 5'(n);
                4:       cnt = 5'(n + 1);
                5:       cnt = 5'd31;
                default: cnt = 5'($urandom_range(0, 31));
            endcase
            w.src_value = {upper[31:5], cnt};
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            w.src_value = ($urandom_range(0, 1) == 1) ? w.dest_value : ~w.dest_value;
        end
        else
        begin
            w.src_value = upper;
        end
        return w;
    endfunction

    // Offers one request word after an idle gap and waits for it to be taken.
    task send_request(req_word_t w, int gap);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= w.req_type;
        req_ch.dest_value <= w.dest_value;
        req_ch.src_value  <= w.src_value;
        req_ch.width_code <= w.width_code;
        do
            @(posedge clk);
        while (!req_ch.ready);
        board.note_request(w);
        accepted_reqs++;
    endtask

    // Response side: random stalls per word, with stall-free stretches.
    initial
    begin
        int        wait_left;
        int        seen;
        bit        no_stall;
        rsp_word_t got;

        wait_left    = 0;
        seen         = 0;
        no_stall     = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.result_value  = rsp_ch.result_value;
                got.write_back    = rsp_ch.write_back;
                got.carry_flag    = rsp_ch.carry_flag;
                got.overflow_flag = rsp_ch.overflow_flag;
                got.zero_flag     = rsp_ch.zero_flag;
                got.sign_flag     = rsp_ch.sign_flag;
                board.check_response(got);
                seen++;
                if (seen % 40 == 0)
                    no_stall = ($urandom_range(0, 2) == 0);
                wait_left = no_stall ? 0 : $urandom_range(0, MAX_GAP);
            end
            rsp_ch.ready <= (wait_left == 0) && !hold_rsp;
            if (wait_left > 0)
                wait_left--;
        end
    end

    // One long hold on the response side while requests keep coming.
    initial
    begin
        hold_rsp = 1'b0;
        wait (accepted_reqs >= 150);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    // Reset, directed words, random words, then drain.
    initial
    begin
        req_word_t directed[$];
        int        i;
        bit        no_gap;

        rst_n             = 1'b0;
        accepted_reqs     = 0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = OP_TEST;
        req_ch.dest_value = '0;
        req_ch.src_value  = '0;
        req_ch.width_code = WC_BYTE;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Operand extremes, every operation and the corner cases of counts and flags.
        directed.push_back(make_req(OP_TEST, 32'hffff_ffff, 32'h0000_0000, WC_DWORD));
        directed.push_back(make_req(OP_AND,  32'hffff_ffff, 32'hffff_ffff, WC_DWORD));
        directed.push_back(make_req(OP_XOR,  32'h0000_0080, 32'h0000_007f, WC_BYTE));
        directed.push_back(make_req(OP_OR,   32'h0000_0000, 32'h0000_0000, WC_WORD));
        directed.push_back(make_req(OP_NOT,  32'hffff_ffff, 32'h0000_0000, WC_DWORD));
        directed.push_back(make_req(OP_SHL,  32'h0000_0081, 32'h0000_0001, WC_BYTE));
        directed.push_back(make_req(OP_SHL,  32'h0000_8001, 32'hffff_ffe0, WC_WORD));
        directed.push_back(make_req(OP_SHL,  32'h0000_0001, 32'h0000_001f, WC_SPARE));
        directed.push_back(make_req(OP_SHR,  32'h0000_ffff, 32'h0000_0010, WC_WORD));
        directed.push_back(make_req(OP_SAR,  32'h0000_0080, 32'h0000_0009, WC_BYTE));
        directed.push_back(make_req(OP_SAR,  32'h8000_0000, 32'h0000_001f, WC_DWORD));
        directed.push_back(make_req(OP_ROL,  32'h0000_0080, 32'h0000_0001, WC_BYTE));
        directed.push_back(make_req(OP_ROR,  32'h0000_0001, 32'h0000_0001, WC_WORD));
        directed.push_back(make_req(OP_ROL,  32'h1234_5678, 32'h0000_0020, WC_DWORD));
        directed.push_back(make_req(OP_ROR,  32'h0000_00a5, 32'h0000_0008, WC_BYTE));
        directed.push_back(make_req(OP_SHL,  32'hffff_ffff, 32'h0000_0001, WC_DWORD));
        directed.push_back(make_req(OP_RCL,  32'h0000_0080, 32'h0000_0001, WC_BYTE));
        directed.push_back(make_req(OP_RCR,  32'h0000_0001, 32'h0000_0001, WC_BYTE));
        directed.push_back(make_req(OP_RCL,  32'h0000_ffff, 32'h0000_0011, WC_WORD));
        directed.push_back(make_req(OP_RCR,  32'h1234_5678, 32'h0000_001f, WC_DWORD));
        directed.push_back(make_req(OP_RCL,  32'h8000_0001, 32'h0000_0001, WC_SPARE));
        directed.push_back(make_req(OP_SPARE_LO, 32'hffff_ffff, 32'h1234_5678, WC_BYTE));
        directed.push_back(make_req(OP_SPARE_HI, 32'hdead_beef, 32'hffff_ffff, WC_SPARE));
        directed.push_back(make_req(OP_NOT,  32'h0000_0000, 32'hffff_ffff, WC_SPARE));
        directed.push_back(make_req(OP_TEST, 32'h0000_0080, 32'h0000_0080, WC_BYTE));

        foreach (directed[k])
            send_request(directed[k], $urandom_range(0, 3));

        // Random words in stretches, some without any idle gaps.
        no_gap = 1'b0;
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 50 == 0)
                no_gap = ($urandom_range(0, 2) == 0);
            send_request(random_req(), no_gap ? 0 : $urandom_range(0, MAX_GAP));
        end
        req_ch.valid <= 1'b0;

        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.pending_results.size() != 0)
            board.report($sformatf("%0d expected words never arrived",
                                   board.pending_results.size()));

        $display("Run covered %0d request words (%0d directed) and %0d checked responses,",
                 accepted_reqs, directed.size(), board.checked);
        $display("all operations and size codes, with one long response hold; %0d mismatches.",
                 board.mismatches);
        if (board.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
